// ===== design/x86_instruction_byte_encoder_assert.svh =====
// Assertion macros for the x86 instruction byte encoder.
`ifndef X86_INSTRUCTION_BYTE_ENCODER_ASSERT_SVH
`define X86_INSTRUCTION_BYTE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every enabled edge.
`define XIBE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("x86 byte encoder: invariant violated");
// Antecedent at one edge forces the consequent at the next edge.
`define XIBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("x86 byte encoder: sequence violated");
`else
`define XIBE_ASSERT_ALWAYS(label, clk, rst, cond)
`define XIBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/xibe_pkg.sv =====
// Shared types, codes, tables and helpers of the x86 instruction byte encoder.
`default_nettype none
package xibe_pkg;

   localparam int MAX_BYTES   = 7;
   localparam int QUEUE_DEPTH = 2;

   // Operation codes.
   localparam logic [3:0] MODE_MOV  = 4'd0;
   localparam logic [3:0] MODE_ADD  = 4'd1;
   localparam logic [3:0] MODE_SUB  = 4'd2;
   localparam logic [3:0] MODE_PUSH = 4'd3;
   localparam logic [3:0] MODE_POP  = 4'd4;
   localparam logic [3:0] MODE_INT  = 4'd5;
   localparam logic [3:0] MODE_NOP  = 4'd6;
   localparam logic [3:0] MODE_HLT  = 4'd7;
   localparam logic [3:0] MODE_CLI  = 4'd8;
   localparam logic [3:0] MODE_STI  = 4'd9;
   localparam logic [3:0] MODE_RET  = 4'd10;
   localparam logic [3:0] MODE_CALL = 4'd11;
   localparam logic [3:0] MODE_JMP  = 4'd12;

   // Operand kinds.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_REG   = 3'd1;
   localparam logic [2:0] KIND_IMM   = 3'd2;
   localparam logic [2:0] KIND_MEM   = 3'd3;
   localparam logic [2:0] KIND_LABEL = 3'd4;

   // Opcode bytes.
   localparam logic [7:0] OP_MOV_RI8   = 8'hB0;
   localparam logic [7:0] OP_MOV_RI    = 8'hB8;
   localparam logic [7:0] OP_PREFIX16  = 8'h66;
   localparam logic [7:0] OP_MOV_RR8   = 8'h88;
   localparam logic [7:0] OP_MOV_RM    = 8'h89;
   localparam logic [7:0] OP_MOV_MR    = 8'h8B;
   localparam logic [7:0] OP_ALU_I8    = 8'h80;
   localparam logic [7:0] OP_ALU_I     = 8'h81;
   localparam logic [7:0] OP_PUSH_I8   = 8'h6A;
   localparam logic [7:0] OP_PUSH_I32  = 8'h68;
   localparam logic [7:0] OP_PUSH_R    = 8'h50;
   localparam logic [7:0] OP_POP_R     = 8'h58;
   localparam logic [7:0] OP_INT       = 8'hCD;
   localparam logic [7:0] OP_NOP       = 8'h90;
   localparam logic [7:0] OP_HLT       = 8'hF4;
   localparam logic [7:0] OP_CLI       = 8'hFA;
   localparam logic [7:0] OP_STI       = 8'hFB;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_CALL      = 8'hE8;
   localparam logic [7:0] OP_JMP_SHORT = 8'hEB;

   localparam logic [2:0] EXT_ADD = 3'd0;
   localparam logic [2:0] EXT_SUB = 3'd5;
   localparam logic [2:0] RM_DISP32 = 3'd5;

   typedef enum logic [1:0] {
      SZ_NONE,
      SZ_8,
      SZ_16,
      SZ_32
   } size_type;

   // One encoded instruction: bytes in emission order, count, error flag.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                len;
      logic                      err;
   } enc_type;

   // Head of the instruction queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      enc_type item;
   } qhead_type;

   function automatic logic [2:0] reg_code(input logic [4:0] idx);
      logic [2:0] code;
      begin
         unique case (idx) inside
            5'd24:   code = 3'd1;
            5'd25:   code = 3'd3;
            5'd26:   code = 3'd0;
            5'd27:   code = 3'd4;
            5'd28:   code = 3'd5;
            5'd29:   code = 3'd2;
            5'd30,
            5'd31:   code = 3'd0;
            default: code = idx[2:0];
         endcase
         return code;
      end
   endfunction

   function automatic size_type reg_size(input logic [4:0] idx);
      size_type sz;
      begin
         if (idx < 5'd8) begin
            sz = SZ_8;
         end else if (idx < 5'd16) begin
            sz = SZ_16;
         end else if (idx < 5'd24) begin
            sz = SZ_32;
         end else if (idx < 5'd30) begin
            sz = SZ_16;
         end else begin
            sz = SZ_NONE;
         end
         return sz;
      end
   endfunction

   function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                        input logic [2:0] rm);
      return {md, rg, rm};
   endfunction

endpackage
`default_nettype wire

// ===== design/xibe_front.sv =====
// Front end: accepts a decoded instruction and encodes it into a byte group.
`default_nettype none
module xibe_front
   import xibe_pkg::*;
(
   input  wire logic        push,
   input  wire logic        q_full,
   input  wire logic [3:0]  req_mode,
   input  wire logic [2:0]  req_first_kind,
   input  wire logic [2:0]  req_second_kind,
   input  wire logic [4:0]  req_first_reg,
   input  wire logic [4:0]  req_second_reg,
   input  wire logic [31:0] req_first_imm,
   input  wire logic [31:0] req_second_imm,
   input  wire logic [31:0] req_first_mem_offset,
   input  wire logic [31:0] req_second_mem_offset,
   output logic             q_wr,
   output enc_type          q_item
);

   logic [MAX_BYTES-1:0][7:0] b;
   logic [2:0]                n;
   logic                      ok;
   logic [2:0]                c0, c1;
   size_type                  s0, s1;
   logic [2:0]                ext;
   logic [7:0]                stack_op;
   logic [31:0]               imm0, imm1, mem0, mem1;

   assign q_wr = push & ~q_full;

   assign c0   = reg_code(req_first_reg);
   assign c1   = reg_code(req_second_reg);
   assign s0   = reg_size(req_first_reg);
   assign s1   = reg_size(req_second_reg);
   assign imm0 = req_first_imm;
   assign imm1 = req_second_imm;
   assign mem0 = req_first_mem_offset;
   assign mem1 = req_second_mem_offset;
   assign ext      = (req_mode == MODE_ADD) ? EXT_ADD : EXT_SUB;
   assign stack_op = (req_mode == MODE_PUSH) ? OP_PUSH_R : OP_POP_R;

   always_comb begin
      b  = '0;
      n  = 3'd1;
      ok = 1'b1;
      unique case (req_mode) inside
         MODE_MOV: begin
            if (req_first_kind == KIND_REG && req_second_kind == KIND_IMM) begin
               if (s0 == SZ_8) begin
                  b[0] = OP_MOV_RI8 + {5'd0, c0};
                  b[1] = imm1[7:0];
                  n    = 3'd2;
               end else if (s0 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = OP_MOV_RI + {5'd0, c0};
                  b[2] = imm1[7:0];
                  b[3] = imm1[15:8];
                  n    = 3'd4;
               end else begin
                  b[0] = OP_MOV_RI + {5'd0, c0};
                  b[1] = imm1[7:0];
                  b[2] = imm1[15:8];
                  b[3] = imm1[23:16];
                  b[4] = imm1[31:24];
                  n    = 3'd5;
               end
            end else if (req_first_kind == KIND_REG && req_second_kind == KIND_REG) begin
               if (s0 != s1) begin
                  ok = 1'b0;
               end else if (s0 == SZ_8) begin
                  b[0] = OP_MOV_RR8;
                  b[1] = modrm(2'd3, c1, c0);
                  n    = 3'd2;
               end else if (s0 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = OP_MOV_RM;
                  b[2] = modrm(2'd3, c1, c0);
                  n    = 3'd3;
               end else begin
                  b[0] = OP_MOV_RM;
                  b[1] = modrm(2'd3, c1, c0);
                  n    = 3'd2;
               end
            end else if (req_first_kind == KIND_REG && req_second_kind == KIND_MEM) begin
               if (s0 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = OP_MOV_MR;
                  b[2] = modrm(2'd0, c0, RM_DISP32);
                  b[3] = mem1[7:0];
                  b[4] = mem1[15:8];
                  b[5] = mem1[23:16];
                  b[6] = mem1[31:24];
                  n    = 3'd7;
               end else if (s0 == SZ_32) begin
                  b[0] = OP_MOV_MR;
                  b[1] = modrm(2'd0, c0, RM_DISP32);
                  b[2] = mem1[7:0];
                  b[3] = mem1[15:8];
                  b[4] = mem1[23:16];
                  b[5] = mem1[31:24];
                  n    = 3'd6;
               end else begin
                  ok = 1'b0;
               end
            end else if (req_first_kind == KIND_MEM && req_second_kind == KIND_REG) begin
               if (s1 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = OP_MOV_RM;
                  b[2] = modrm(2'd0, c1, RM_DISP32);
                  b[3] = mem0[7:0];
                  b[4] = mem0[15:8];
                  b[5] = mem0[23:16];
                  b[6] = mem0[31:24];
                  n    = 3'd7;
               end else if (s1 == SZ_32) begin
                  b[0] = OP_MOV_RM;
                  b[1] = modrm(2'd0, c1, RM_DISP32);
                  b[2] = mem0[7:0];
                  b[3] = mem0[15:8];
                  b[4] = mem0[23:16];
                  b[5] = mem0[31:24];
                  n    = 3'd6;
               end else begin
                  ok = 1'b0;
               end
            end else begin
               ok = 1'b0;
            end
         end
         MODE_ADD, MODE_SUB: begin
            if (req_first_kind == KIND_REG && req_second_kind == KIND_IMM) begin
               if (s0 == SZ_8) begin
                  b[0] = OP_ALU_I8;
                  b[1] = modrm(2'd3, ext, c0);
                  b[2] = imm1[7:0];
                  n    = 3'd3;
               end else if (s0 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = OP_ALU_I;
                  b[2] = modrm(2'd3, ext, c0);
                  b[3] = imm1[7:0];
                  b[4] = imm1[15:8];
                  n    = 3'd5;
               end else begin
                  b[0] = OP_ALU_I;
                  b[1] = modrm(2'd3, ext, c0);
                  b[2] = imm1[7:0];
                  b[3] = imm1[15:8];
                  b[4] = imm1[23:16];
                  b[5] = imm1[31:24];
                  n    = 3'd6;
               end
            end else begin
               ok = 1'b0;
            end
         end
         MODE_PUSH, MODE_POP: begin
            if (req_first_kind == KIND_REG) begin
               if (s0 == SZ_16) begin
                  b[0] = OP_PREFIX16;
                  b[1] = stack_op + {5'd0, c0};
                  n    = 3'd2;
               end else begin
                  b[0] = stack_op + {5'd0, c0};
                  n    = 3'd1;
               end
            end else if (req_mode == MODE_PUSH && req_first_kind == KIND_IMM) begin
               // Short form when the value is a sign-extended byte.
               if (imm0[31:7] == 25'd0 || imm0[31:7] == '1) begin
                  b[0] = OP_PUSH_I8;
                  b[1] = imm0[7:0];
                  n    = 3'd2;
               end else begin
                  b[0] = OP_PUSH_I32;
                  b[1] = imm0[7:0];
                  b[2] = imm0[15:8];
                  b[3] = imm0[23:16];
                  b[4] = imm0[31:24];
                  n    = 3'd5;
               end
            end else begin
               ok = 1'b0;
            end
         end
         MODE_INT: begin
            if (req_first_kind == KIND_IMM) begin
               b[0] = OP_INT;
               b[1] = imm0[7:0];
               n    = 3'd2;
            end else begin
               ok = 1'b0;
            end
         end
         MODE_NOP: b[0] = OP_NOP;
         MODE_HLT: b[0] = OP_HLT;
         MODE_CLI: b[0] = OP_CLI;
         MODE_STI: b[0] = OP_STI;
         MODE_RET: b[0] = OP_RET;
         MODE_CALL: begin
            if (req_first_kind == KIND_LABEL) begin
               b[0] = OP_CALL;
               n    = 3'd5;
            end else begin
               ok = 1'b0;
            end
         end
         MODE_JMP: begin
            if (req_first_kind == KIND_LABEL) begin
               b[0] = OP_JMP_SHORT;
               n    = 3'd2;
            end else begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
   end

   // Drop the bytes on an unsupported form: one zero result flagged as error.
   always_comb begin
      if (ok) begin
         q_item.bytes = b;
         q_item.len   = n;
         q_item.err   = 1'b0;
      end else begin
         q_item.bytes = '0;
         q_item.len   = 3'd1;
         q_item.err   = 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== design/xibe_fifo.sv =====
// Short queue of encoded instructions between front and back end.
`default_nettype none
module xibe_fifo
   import xibe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr,
   input  wire enc_type wr_item,
   input  wire logic    rd,
   output logic         full,
   output qhead_type    head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   enc_type         mem [DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_rd;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.item  = mem[rptr_ff];
   assign do_rd      = rd & head.valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (wr) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({wr, do_rd})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wptr_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

// ===== design/xibe_back.sv =====
// Back end: serializes one encoded instruction into single-byte results.
`default_nettype none
module xibe_back
   import xibe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qhead_type   head,
   output logic             q_rd,
   input  wire logic        pop,
   output logic             empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_error
);

   enc_type     cur_ff, cur_in;
   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic        take;
   logic        cur_last;

   assign cur_last = (idx_ff == cur_ff.len - 3'd1);
   assign take     = valid_ff & pop;
   // Load the next group when idle or when the final byte transfers.
   assign q_rd     = head.valid & (~valid_ff | (take & cur_last));

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (q_rd) begin
         cur_in   = head.item;
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (take) begin
         if (cur_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign empty        = ~valid_ff;
   assign rsp_out_byte = cur_ff.bytes[idx_ff];
   assign rsp_last     = cur_last;
   assign rsp_error    = cur_ff.err;

endmodule
`default_nettype wire

// ===== design/x86_instruction_byte_encoder.sv =====
// Top level of the x86 instruction byte encoder.
// Usage:
//  - Input queue port: drive the decoded instruction on the req_ ports and raise push;
//    the instruction transfers at a rising edge with push high and full low.
//  - Result queue port: while empty is low, rsp_out_byte, rsp_last and rsp_error show
//    the oldest pending byte; it transfers at a rising edge with pop high.
//  - Each instruction yields 1 to 7 bytes in emission order, rsp_last on the final one.
//    An unsupported operand combination yields one zero byte with rsp_error and
//    rsp_last set.
//  - With the back end idle, the transfer edge writes the queue and the edge after it
//    loads the output register, which then shows the first byte.
//  - Throughput: one byte per cycle on the result side while pop is high, set by the
//    single-byte output register. The encoder takes a new instruction every cycle while
//    the queue has room.
//  - Reset: synchronous; empties the queue and the output register, no clearing pass.
//  - Result stall: hold pop low and the current byte holds; the queue fills and then
//    full rises, which stalls the input side.
`default_nettype none
`include "x86_instruction_byte_encoder_assert.svh"
module x86_instruction_byte_encoder
   import xibe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_mode,
   input  wire logic [2:0]  req_first_kind,
   input  wire logic [2:0]  req_second_kind,
   input  wire logic [4:0]  req_first_reg,
   input  wire logic [4:0]  req_second_reg,
   input  wire logic [31:0] req_first_imm,
   input  wire logic [31:0] req_second_imm,
   input  wire logic [31:0] req_first_mem_offset,
   input  wire logic [31:0] req_second_mem_offset,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_error
);

   logic      q_wr;
   logic      q_rd;
   enc_type   q_item;
   qhead_type q_head;

   // Encode the instruction and write it straight into the queue.
   xibe_front u_front (
      .push                  (push),
      .q_full                (full),
      .req_mode              (req_mode),
      .req_first_kind        (req_first_kind),
      .req_second_kind       (req_second_kind),
      .req_first_reg         (req_first_reg),
      .req_second_reg        (req_second_reg),
      .req_first_imm         (req_first_imm),
      .req_second_imm        (req_second_imm),
      .req_first_mem_offset  (req_first_mem_offset),
      .req_second_mem_offset (req_second_mem_offset),
      .q_wr                  (q_wr),
      .q_item                (q_item)
   );

   // Decouple the encoder from the byte stream.
   xibe_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_item (q_item),
      .rd      (q_rd),
      .full    (full),
      .head    (q_head)
   );

   // Advance through the bytes of the head instruction, one per transfer.
   xibe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_rd         (q_rd),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

   // An error result is a single zero byte that closes its instruction.
   `XIBE_ASSERT_ALWAYS(a_err_last, clock, reset, empty || !rsp_error || rsp_last)
   `XIBE_ASSERT_ALWAYS(a_err_zero, clock, reset, empty || !rsp_error || rsp_out_byte == 8'h00)
   // A waiting instruction reaches the output register on the next edge.
   `XIBE_ASSERT_NEXT(a_load, clock, reset, empty && q_head.valid, !empty)
   // A byte that is not the last one is followed by more bytes.
   `XIBE_ASSERT_NEXT(a_more, clock, reset, pop && !empty && !rsp_last, !empty)

endmodule
`default_nettype wire
